// ===== sv/mps_pkg.sv =====
package mps_pkg;

	localparam int GRID_ROWS_DEF   = 16;
	localparam int GRID_COLS_DEF   = 16;
	localparam int STACK_DEPTH_DEF = 256;

	// Command codes of an input item.
	localparam logic [1:0] CMD_WRITE_CELL = 2'd0;
	localparam logic [1:0] CMD_SEARCH     = 2'd1;
	localparam logic [1:0] CMD_READ_PATH  = 2'd2;
	localparam logic [1:0] CMD_READ_MARK  = 2'd3;

	// Cell marks.
	localparam logic [1:0] MARK_OPEN = 2'd0;
	localparam logic [1:0] MARK_WALL = 2'd1;
	localparam logic [1:0] MARK_PATH = 2'd2;
	localparam logic [1:0] MARK_DEAD = 2'd3;

	// Search directions, tried in this order.
	localparam logic [1:0] DIR_EAST  = 2'd0;
	localparam logic [1:0] DIR_SOUTH = 2'd1;
	localparam logic [1:0] DIR_WEST  = 2'd2;
	localparam logic [1:0] DIR_NORTH = 2'd3;

	// Configuration register indexes.
	localparam logic [1:0] REG_START_ROW = 2'd0;
	localparam logic [1:0] REG_START_COL = 2'd1;
	localparam logic [1:0] REG_GOAL_ROW  = 2'd2;
	localparam logic [1:0] REG_GOAL_COL  = 2'd3;

	localparam logic [3:0] START_ROW_RST = 4'd1;
	localparam logic [3:0] START_COL_RST = 4'd1;
	localparam logic [3:0] GOAL_ROW_RST  = 4'd8;
	localparam logic [3:0] GOAL_COL_RST  = 4'd8;

	typedef struct packed {
		logic load;
		logic cell_wr;
		logic srch_init;
		logic push;
		logic pop;
		logic advance;
		logic res_sel;
		logic result;
	} mps_ctl_t;

	typedef struct packed {
		logic can_push;
		logic at_goal;
		logic sp_zero;
		logic top_last;
	} mps_sts_t;

endpackage

// ===== sv/maze_path_stack_search.sv =====
// Depth-first maze solver over a grid of up to 16 x 16 cells. Raise start with a command
// while busy is low; the result appears on the output ports for exactly one cycle with done
// high and cannot be held off, so the receiver must take it then. A cell write passes through
// the write, result-read and result states before done; a path or mark read goes straight to
// the result read. In a search each candidate cell costs a grid memory read and a decision
// state, and each backtracking step a stack memory read and an update state.
// Cell marks persist between searches; rewrite cells to open before a new search is to pass
// them. Configuration writes are taken at any edge with cfg_write high and must only be made
// while busy is low.
module maze_path_stack_search #(
	parameter int GRID_ROWS   = mps_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS   = mps_pkg::GRID_COLS_DEF,
	parameter int STACK_DEPTH = mps_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] command,
	input  logic [3:0] cell_row,
	input  logic [3:0] cell_col,
	input  logic       is_wall,
	input  logic [7:0] path_index,
	input  logic       cfg_write,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data,
	output logic       done,
	output logic       found,
	output logic [8:0] path_length,
	output logic [3:0] step_row,
	output logic [3:0] step_col,
	output logic [1:0] cell_mark
);
	import mps_pkg::*;

	mps_ctl_t ctl;
	mps_sts_t sts;

	mps_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.command (command),
		.sts     (sts),
		.ctl     (ctl),
		.busy    (busy)
	);

	mps_dp #(
		.GRID_ROWS   (GRID_ROWS),
		.GRID_COLS   (GRID_COLS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.sts         (sts),
		.command     (command),
		.cell_row    (cell_row),
		.cell_col    (cell_col),
		.is_wall     (is_wall),
		.path_index  (path_index),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.found       (found),
		.path_length (path_length),
		.step_row    (step_row),
		.step_col    (step_col),
		.cell_mark   (cell_mark)
	);

endmodule

// ===== sv/mps_ctrl.sv =====
module mps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [1:0]        command,
	input  mps_pkg::mps_sts_t sts,
	output mps_pkg::mps_ctl_t ctl,
	output logic              busy
);
	import mps_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_WRITE  = 4'd1;
	localparam logic [3:0] S_INIT   = 4'd2;
	localparam logic [3:0] S_CHECK  = 4'd3;
	localparam logic [3:0] S_EVAL   = 4'd4;
	localparam logic [3:0] S_POP_RD = 4'd5;
	localparam logic [3:0] S_POP_EV = 4'd6;
	localparam logic [3:0] S_RES_RD = 4'd7;
	localparam logic [3:0] S_RES    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					unique case (command)
						CMD_WRITE_CELL: state_nxt = S_WRITE;
						CMD_SEARCH:     state_nxt = S_INIT;
						default:        state_nxt = S_RES_RD;
					endcase
				end
			end
			S_WRITE: begin
				ctl.cell_wr = 1'b1;
				state_nxt   = S_RES_RD;
			end
			S_INIT: begin
				ctl.srch_init = 1'b1;
				state_nxt     = S_CHECK;
			end
			S_CHECK: begin
				state_nxt = S_EVAL;
			end
			S_EVAL: begin
				if (sts.can_push) begin
					ctl.push  = 1'b1;
					state_nxt = sts.at_goal ? S_RES_RD : S_CHECK;
				end else begin
					state_nxt = S_POP_RD;
				end
			end
			S_POP_RD: begin
				state_nxt = sts.sp_zero ? S_RES_RD : S_POP_EV;
			end
			S_POP_EV: begin
				if (sts.top_last) begin
					ctl.pop   = 1'b1;
					state_nxt = S_POP_RD;
				end else begin
					ctl.advance = 1'b1;
					state_nxt   = S_CHECK;
				end
			end
			S_RES_RD: begin
				ctl.res_sel = 1'b1;
				state_nxt   = S_RES;
			end
			S_RES: begin
				ctl.result = 1'b1;
				state_nxt  = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy = (state_q != S_IDLE);

`ifndef ASSERT_OFF
	// The evaluation of a candidate always uses the read issued in the cycle before.
	a_eval_after_check: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EVAL |-> $past(state_q) == S_CHECK)
		else $error("evaluation without a preceding grid read");

	// A popped entry was read from the stack in the cycle before.
	a_pop_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_POP_EV |-> $past(state_q) == S_POP_RD)
		else $error("stack entry used without a read");
`endif

endmodule

// ===== sv/mps_dp.sv =====
module mps_dp #(
	parameter int GRID_ROWS   = mps_pkg::GRID_ROWS_DEF,
	parameter int GRID_COLS   = mps_pkg::GRID_COLS_DEF,
	parameter int STACK_DEPTH = mps_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mps_pkg::mps_ctl_t ctl,
	output mps_pkg::mps_sts_t sts,
	input  logic [1:0]        command,
	input  logic [3:0]        cell_row,
	input  logic [3:0]        cell_col,
	input  logic              is_wall,
	input  logic [7:0]        path_index,
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [3:0]        cfg_data,
	output logic              done,
	output logic              found,
	output logic [8:0]        path_length,
	output logic [3:0]        step_row,
	output logic [3:0]        step_col,
	output logic [1:0]        cell_mark
);
	import mps_pkg::*;

	localparam int GAW   = $clog2(GRID_ROWS) + 4;
	localparam int CELLS = 1 << GAW;
	localparam int SAW   = $clog2(STACK_DEPTH);
	localparam int SPW   = $clog2(STACK_DEPTH + 1);

	// Stack entry: row, column, direction last tried.
	typedef struct packed {
		logic [3:0] row;
		logic [3:0] col;
		logic [1:0] dir;
	} entry_t;

	// Neighbour of a cell; the top bit flags a step off the grid. Stepping west
	// or north from index zero wraps to 31 in five bits and so fails the compare.
	function automatic logic [8:0] step_to(input logic [3:0] r, input logic [3:0] c,
			input logic [1:0] d);
		logic [4:0] nr;
		logic [4:0] nc;
		nr = {1'b0, r};
		nc = {1'b0, c};
		unique case (d)
			DIR_EAST:  nc = nc + 5'd1;
			DIR_SOUTH: nr = nr + 5'd1;
			DIR_WEST:  nc = nc - 5'd1;
			default:   nr = nr - 5'd1;
		endcase
		return {(nr >= 5'(GRID_ROWS)) || (nc >= 5'(GRID_COLS)), nr[3:0], nc[3:0]};
	endfunction

	function automatic logic [GAW-1:0] cell_addr(input logic [3:0] r, input logic [3:0] c);
		logic [7:0] a;
		a = {r, c};
		return a[GAW-1:0];
	endfunction

	// Configuration.
	logic [3:0] start_row_q, start_col_q, goal_row_q, goal_col_q;

	// Latched item.
	logic [1:0] cmd_q;
	logic [3:0] row_q, col_q;
	logic       wall_q;
	logic [7:0] idx_q;
	logic       item_oob;

	// Search state.
	logic [3:0]     cand_row_q, cand_col_q;
	logic           cand_oob_q;
	logic [SPW-1:0] sp_q;
	logic           found_q;

	// Memories and their read registers.
	logic [1:0]     grid_mem [CELLS];
	logic [CELLS-1:0] vld_q;
	logic [1:0]     g_rd_q;
	logic           g_vld_q;
	entry_t         stack_mem [STACK_DEPTH];
	entry_t         s_rd_q;

	logic           g_we;
	logic [GAW-1:0] g_waddr;
	logic [1:0]     g_wdata;
	logic [GAW-1:0] g_raddr;
	logic           s_we;
	logic [SAW-1:0] s_waddr;
	entry_t         s_wdata;
	logic [SAW-1:0] s_raddr;
	logic [SPW-1:0] sp_dec;
	logic [1:0]     mark_rd;
	logic [8:0]     east_nb;
	logic [8:0]     adv_nb;
	logic [1:0]     adv_dir;

	assign item_oob = ({1'b0, row_q} >= 5'(GRID_ROWS)) || ({1'b0, col_q} >= 5'(GRID_COLS));
	assign sp_dec   = sp_q - SPW'(1);
	assign mark_rd  = g_vld_q ? g_rd_q : MARK_OPEN;
	assign east_nb  = step_to(cand_row_q, cand_col_q, DIR_EAST);
	assign adv_dir  = s_rd_q.dir + 2'd1;
	assign adv_nb   = step_to(s_rd_q.row, s_rd_q.col, adv_dir);

	assign sts.can_push = !cand_oob_q && (mark_rd == MARK_OPEN)
		&& (sp_q != SPW'(STACK_DEPTH));
	assign sts.at_goal  = (cand_row_q == goal_row_q) && (cand_col_q == goal_col_q);
	assign sts.sp_zero  = (sp_q == '0);
	assign sts.top_last = (s_rd_q.dir == DIR_NORTH);

	always_comb begin
		g_we    = 1'b0;
		g_waddr = cell_addr(cand_row_q, cand_col_q);
		g_wdata = MARK_PATH;
		if (ctl.cell_wr) begin
			g_we    = !item_oob;
			g_waddr = cell_addr(row_q, col_q);
			g_wdata = wall_q ? MARK_WALL : MARK_OPEN;
		end else if (ctl.push) begin
			g_we = 1'b1;
		end else if (ctl.pop) begin
			g_we    = 1'b1;
			g_waddr = cell_addr(s_rd_q.row, s_rd_q.col);
			g_wdata = MARK_DEAD;
		end
	end

	always_comb begin
		s_we    = ctl.push || ctl.advance;
		s_waddr = ctl.push ? sp_q[SAW-1:0] : sp_dec[SAW-1:0];
		s_wdata = ctl.push ? entry_t'{row: cand_row_q, col: cand_col_q, dir: DIR_EAST}
			: entry_t'{row: s_rd_q.row, col: s_rd_q.col, dir: adv_dir};
	end

	assign g_raddr = ctl.res_sel ? cell_addr(row_q, col_q) : cell_addr(cand_row_q, cand_col_q);
	assign s_raddr = ctl.res_sel ? idx_q[SAW-1:0] : sp_dec[SAW-1:0];

	always_ff @(posedge clk) begin
		if (g_we) begin
			grid_mem[g_waddr] <= g_wdata;
		end
		g_rd_q <= grid_mem[g_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			stack_mem[s_waddr] <= s_wdata;
		end
		s_rd_q <= stack_mem[s_raddr];
	end

	// A cell that was never written reads as open.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			g_vld_q <= 1'b0;
		end else begin
			if (g_we) begin
				vld_q[g_waddr] <= 1'b1;
			end
			g_vld_q <= vld_q[g_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_row_q <= START_ROW_RST;
			start_col_q <= START_COL_RST;
			goal_row_q  <= GOAL_ROW_RST;
			goal_col_q  <= GOAL_COL_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_START_ROW: start_row_q <= cfg_data;
				REG_START_COL: start_col_q <= cfg_data;
				REG_GOAL_ROW:  goal_row_q  <= cfg_data;
				default:       goal_col_q  <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q  <= command;
			row_q  <= cell_row;
			col_q  <= cell_col;
			wall_q <= is_wall;
			idx_q  <= path_index;
		end
		if (ctl.srch_init) begin
			cand_row_q <= start_row_q;
			cand_col_q <= start_col_q;
			cand_oob_q <= ({1'b0, start_row_q} >= 5'(GRID_ROWS))
				|| ({1'b0, start_col_q} >= 5'(GRID_COLS));
		end else if (ctl.push) begin
			{cand_oob_q, cand_row_q, cand_col_q} <= east_nb;
		end else if (ctl.advance) begin
			{cand_oob_q, cand_row_q, cand_col_q} <= adv_nb;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q    <= '0;
			found_q <= 1'b0;
		end else if (ctl.srch_init) begin
			sp_q    <= '0;
			found_q <= 1'b0;
		end else if (ctl.push) begin
			sp_q    <= sp_q + SPW'(1);
			found_q <= sts.at_goal;
		end else if (ctl.pop) begin
			sp_q <= sp_dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl.result;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.result) begin
			found       <= found_q;
			path_length <= 9'(sp_q);
			if ((cmd_q == CMD_READ_PATH) && (9'(idx_q) < 9'(sp_q))) begin
				step_row <= s_rd_q.row;
				step_col <= s_rd_q.col;
			end else begin
				step_row <= '0;
				step_col <= '0;
			end
			cell_mark <= item_oob ? MARK_WALL : mark_rd;
		end
	end

`ifndef ASSERT_OFF
	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SPW'(STACK_DEPTH))
		else $error("stack pointer beyond stack depth");

	a_found_has_path: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> sp_q != '0)
		else $error("goal reached with an empty path");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_no_write_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({ctl.cell_wr, ctl.push, ctl.pop, ctl.advance}) <= 1)
		else $error("conflicting datapath commands");
`endif

endmodule

// ===== test/tb_maze_path_stack_search.sv =====
`timescale 1ns / 100ps

module tb_maze_path_stack_search;

	import mps_pkg::*;

	localparam int ROWS        = GRID_ROWS_DEF;
	localparam int COLS        = GRID_COLS_DEF;
	localparam int TRAIL_DEPTH = STACK_DEPTH_DEF;
	localparam int CYCLE_LIMIT = 20_000_000;

	typedef struct packed {
		logic       found;
		logic [8:0] path_length;
		logic [3:0] step_row;
		logic [3:0] step_col;
		logic [1:0] cell_mark;
	} outcome_t;

	typedef struct packed {
		logic [3:0] row;
		logic [3:0] col;
		logic [1:0] heading;
	} trail_entry_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [1:0] command = CMD_READ_MARK;
	logic [3:0] cell_row = '0;
	logic [3:0] cell_col = '0;
	logic       is_wall = 1'b0;
	logic [7:0] path_index = '0;
	logic       cfg_write = 1'b0;
	logic [1:0] cfg_index = REG_START_ROW;
	logic [3:0] cfg_data = '0;
	logic       done;
	logic       found;
	logic [8:0] path_length;
	logic [3:0] step_row;
	logic [3:0] step_col;
	logic [1:0] cell_mark;

	// Mirror of the solver: grid marks, path stack and registers.
	logic [1:0]   maze_mark [ROWS][COLS];
	trail_entry_t trail [TRAIL_DEPTH];
	int           trail_len;
	logic         goal_hit;
	logic [3:0]   origin_row, origin_col, target_row, target_col;

	outcome_t outcomes_due [$];
	int       mismatch_count = 0;
	int       cycle_count = 0;
	int       sender_gap_pct = 0;
	int       commands_sent = 0;
	int       cmd_counts [4] = '{0, 0, 0, 0};
	int       goals_reached = 0;
	int       longest_path = 0;

	always #2 clk = ~clk;

	maze_path_stack_search dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.command    (command),
		.cell_row   (cell_row),
		.cell_col   (cell_col),
		.is_wall    (is_wall),
		.path_index (path_index),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.found      (found),
		.path_length(path_length),
		.step_row   (step_row),
		.step_col   (step_col),
		.cell_mark  (cell_mark)
	);

	function automatic logic [1:0] mark_of(int r, int c);
		if (r < 0 || c < 0 || r >= ROWS || c >= COLS)
			return MARK_WALL;
		return maze_mark[r][c];
	endfunction

	// Depth-first walk: east, south, west, north from each cell on the path.
	function automatic void walk_maze();
		int r, c;
		r = int'(origin_row);
		c = int'(origin_col);
		trail_len = 0;
		goal_hit = 1'b0;
		while (1) begin
			if (mark_of(r, c) == MARK_OPEN && trail_len < TRAIL_DEPTH) begin
				maze_mark[r][c] = MARK_PATH;
				trail[trail_len] = '{row: r[3:0], col: c[3:0], heading: DIR_EAST};
				trail_len++;
				if (r == target_row && c == target_col) begin
					goal_hit = 1'b1;
					return;
				end
				c++;
			end else begin
				// Every exhausted entry is marked dead, the bottom one included.
				while (trail_len > 0 && trail[trail_len - 1].heading == DIR_NORTH) begin
					maze_mark[trail[trail_len - 1].row][trail[trail_len - 1].col] = MARK_DEAD;
					trail_len--;
				end
				if (trail_len == 0)
					return;
				trail[trail_len - 1].heading++;
				r = int'(trail[trail_len - 1].row);
				c = int'(trail[trail_len - 1].col);
				case (trail[trail_len - 1].heading)
					DIR_EAST:  c++;
					DIR_SOUTH: r++;
					DIR_WEST:  c--;
					default:   r--;
				endcase
			end
		end
	endfunction

	function automatic outcome_t apply_command(logic [1:0] cmd, logic [3:0] row,
			logic [3:0] col, logic wall, logic [7:0] idx);
		outcome_t o;
		o = '0;
		case (cmd)
			CMD_WRITE_CELL: begin
				if (row < ROWS && col < COLS)
					maze_mark[row][col] = wall ? MARK_WALL : MARK_OPEN;
			end
			CMD_SEARCH: walk_maze();
			CMD_READ_PATH: begin
				if (idx < trail_len) begin
					o.step_row = trail[idx].row;
					o.step_col = trail[idx].col;
				end
			end
			default: ;
		endcase
		o.found = goal_hit;
		o.path_length = trail_len[8:0];
		o.cell_mark = mark_of(int'(row), int'(col));
		return o;
	endfunction

	task automatic report_mismatch(string why, outcome_t want, outcome_t seen);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("Mismatch at %0t (%s): ", $realtime, why,
				"expected found=%0d len=%0d step=(%0d,%0d) mark=%0d, ",
				want.found, want.path_length, want.step_row, want.step_col,
				want.cell_mark,
				"got found=%0d len=%0d step=(%0d,%0d) mark=%0d",
				seen.found, seen.path_length, seen.step_row, seen.step_col,
				seen.cell_mark);
	endtask

	always @(posedge clk) begin
		outcome_t seen, want;
		if (arst_n && done) begin
			seen = '{found: found, path_length: path_length, step_row: step_row,
				step_col: step_col, cell_mark: cell_mark};
			if (outcomes_due.size() == 0) begin
				report_mismatch("result with no command pending", '0, seen);
			end else begin
				want = outcomes_due.pop_front();
				if (seen.found !== want.found || seen.path_length !== want.path_length ||
						seen.step_row !== want.step_row || seen.step_col !== want.step_col ||
						seen.cell_mark !== want.cell_mark)
					report_mismatch("wrong field", want, seen);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
				outcomes_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after the beat is taken,
	// with start still high so that a back-to-back command needs no second assignment.
	task automatic issue_command(logic [1:0] cmd, logic [3:0] row, logic [3:0] col,
			logic wall, logic [7:0] idx);
		int gap;
		outcome_t due;
		gap = ($urandom_range(99) < sender_gap_pct) ? $urandom_range(1, 6) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		command <= cmd;
		cell_row <= row;
		cell_col <= col;
		is_wall <= wall;
		path_index <= idx;
		do @(posedge clk); while (busy);
		due = apply_command(cmd, row, col, wall, idx);
		outcomes_due.push_back(due);
		commands_sent++;
		cmd_counts[cmd]++;
		if (cmd == CMD_SEARCH) begin
			goals_reached += goal_hit;
			if (trail_len > longest_path)
				longest_path = trail_len;
		end
		@(negedge clk);
	endtask

	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (outcomes_due.size() != 0 || busy)
			@(negedge clk);
	endtask

	task automatic set_registers(logic [3:0] sr, logic [3:0] sc, logic [3:0] gr,
			logic [3:0] gc);
		cfg_write <= 1'b1;
		cfg_index <= REG_START_ROW;
		cfg_data <= sr;
		@(negedge clk);
		cfg_index <= REG_START_COL;
		cfg_data <= sc;
		@(negedge clk);
		cfg_index <= REG_GOAL_ROW;
		cfg_data <= gr;
		@(negedge clk);
		cfg_index <= REG_GOAL_COL;
		cfg_data <= gc;
		@(negedge clk);
		cfg_write <= 1'b0;
		origin_row = sr;
		origin_col = sc;
		target_row = gr;
		target_col = gc;
	endtask

	task automatic test_idle_readback();
		issue_command(CMD_READ_MARK, 4'd0, 4'd0, 1'b1, 8'd0);
		issue_command(CMD_READ_PATH, 4'd15, 4'd15, 1'b0, 8'd0);
	endtask

	task automatic test_cell_writes();
		issue_command(CMD_WRITE_CELL, 4'd15, 4'd15, 1'b1, 8'd255);
		issue_command(CMD_WRITE_CELL, 4'd0, 4'd0, 1'b1, 8'd0);
		issue_command(CMD_READ_MARK, 4'd15, 4'd15, 1'b0, 8'd0);
	endtask

	task automatic test_blocked_start();
		drain();
		set_registers(4'd0, 4'd0, 4'd15, 4'd15);
		issue_command(CMD_SEARCH, 4'd0, 4'd0, 1'b0, 8'd0);
		issue_command(CMD_WRITE_CELL, 4'd0, 4'd0, 1'b0, 8'd0);
	endtask

	task automatic test_short_path();
		drain();
		set_registers(4'd0, 4'd0, 4'd0, 4'd3);
		issue_command(CMD_SEARCH, 4'd0, 4'd2, 1'b0, 8'd0);
		issue_command(CMD_READ_PATH, 4'd0, 4'd0, 1'b0, 8'd3);
		issue_command(CMD_READ_PATH, 4'd0, 4'd0, 1'b0, 8'd255);
		// The start cell still carries its path mark, so this search stops at once.
		issue_command(CMD_SEARCH, 4'd0, 4'd1, 1'b0, 8'd0);
		issue_command(CMD_READ_MARK, 4'd0, 4'd1, 1'b0, 8'd0);
	endtask

	task automatic test_exhaustive_search();
		drain();
		set_registers(4'd15, 4'd14, 4'd15, 4'd15);
		issue_command(CMD_SEARCH, 4'd15, 4'd14, 1'b0, 8'd0);
		issue_command(CMD_READ_MARK, 4'd15, 4'd14, 1'b0, 8'd0);
		issue_command(CMD_READ_MARK, 4'd0, 4'd0, 1'b0, 8'd0);
	endtask

	task automatic test_start_equals_goal();
		issue_command(CMD_WRITE_CELL, 4'd7, 4'd7, 1'b0, 8'd0);
		drain();
		set_registers(4'd7, 4'd7, 4'd7, 4'd7);
		issue_command(CMD_SEARCH, 4'd7, 4'd7, 1'b0, 8'd0);
		issue_command(CMD_READ_PATH, 4'd7, 4'd7, 1'b0, 8'd0);
		issue_command(CMD_READ_PATH, 4'd7, 4'd7, 1'b0, 8'd1);
	endtask

	function automatic logic [3:0] pick_coord();
		if ($urandom_range(99) < 20)
			return $urandom_range(1) ? 4'd15 : 4'd0;
		return 4'($urandom_range(15));
	endfunction

	// Each round rebuilds the cells left marked by the last search, searches, and
	// reads the path and marks back; a share of the commands is plain noise.
	task automatic test_random_mazes(int n_items, int gap_pct);
		int first, density, sel, pick;
		logic [3:0] sr, sc, gr, gc;
		logic [7:0] touched [$];
		logic [7:0] spot;
		sender_gap_pct = gap_pct;
		first = commands_sent;
		while (commands_sent - first < n_items) begin
			drain();
			sr = pick_coord();
			sc = pick_coord();
			if ($urandom_range(99) < 10) begin
				gr = sr;
				gc = sc;
			end else begin
				gr = pick_coord();
				gc = pick_coord();
			end
			set_registers(sr, sc, gr, gc);
			density = $urandom_range(10, 45);
			touched.delete();
			for (int r = 0; r < ROWS; r++)
				for (int c = 0; c < COLS; c++)
					if (maze_mark[r][c] == MARK_PATH || maze_mark[r][c] == MARK_DEAD)
						touched.push_back({r[3:0], c[3:0]});
			touched.shuffle();
			foreach (touched[i]) begin
				spot = touched[i];
				issue_command(CMD_WRITE_CELL, spot[7:4], spot[3:0],
					$urandom_range(99) < density, 8'($urandom_range(255)));
			end
			repeat ($urandom_range(0, 4))
				issue_command(CMD_WRITE_CELL, 4'($urandom_range(15)), 4'($urandom_range(15)),
					1'($urandom_range(1)), 8'($urandom_range(255)));
			if ($urandom_range(99) < 85)
				issue_command(CMD_WRITE_CELL, sr, sc, 1'b0, 8'($urandom_range(255)));
			issue_command(CMD_SEARCH, 4'($urandom_range(15)), 4'($urandom_range(15)),
				1'($urandom_range(1)), 8'($urandom_range(255)));
			repeat ($urandom_range(2, 8)) begin
				sel = $urandom_range(99);
				if (sel < 45 && trail_len > 0) begin
					issue_command(CMD_READ_PATH, 4'($urandom_range(15)),
						4'($urandom_range(15)), 1'($urandom_range(1)),
						8'($urandom_range(trail_len - 1, 0)));
				end else if (sel < 60 && trail_len > 0) begin
					pick = $urandom_range(trail_len - 1, 0);
					spot = {trail[pick].row, trail[pick].col};
					issue_command(CMD_READ_MARK, spot[7:4], spot[3:0], 1'($urandom_range(1)),
						8'($urandom_range(255)));
				end else if (sel < 80) begin
					issue_command(CMD_READ_MARK, 4'($urandom_range(15)),
						4'($urandom_range(15)), 1'($urandom_range(1)),
						8'($urandom_range(255)));
				end else if (sel < 90) begin
					issue_command(CMD_READ_PATH, 4'($urandom_range(15)),
						4'($urandom_range(15)), 1'($urandom_range(1)),
						8'($urandom_range(255)));
				end else begin
					issue_command(2'($urandom_range(3)), 4'($urandom_range(15)),
						4'($urandom_range(15)), 1'($urandom_range(1)),
						8'($urandom_range(255)));
				end
			end
		end
	endtask

	initial begin
		for (int r = 0; r < ROWS; r++)
			for (int c = 0; c < COLS; c++)
				maze_mark[r][c] = MARK_OPEN;
		trail_len = 0;
		goal_hit = 1'b0;
		origin_row = START_ROW_RST;
		origin_col = START_COL_RST;
		target_row = GOAL_ROW_RST;
		target_col = GOAL_COL_RST;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		sender_gap_pct = 27;
		test_idle_readback();
		test_cell_writes();
		test_blocked_start();
		test_short_path();
		test_exhaustive_search();
		test_start_equals_goal();
		test_random_mazes(330, 27);
		test_random_mazes(330, 58);
		test_random_mazes(330, 0);

		drain();
		repeat (16) @(negedge clk);

		$display("Ran %0d commands: %0d cell writes, %0d searches ",
			commands_sent, cmd_counts[CMD_WRITE_CELL], cmd_counts[CMD_SEARCH],
			"(%0d reached the goal, longest path %0d)", goals_reached, longest_path);
		$display("Path reads %0d, mark reads %0d, mismatches %0d, results missing %0d",
			cmd_counts[CMD_READ_PATH], cmd_counts[CMD_READ_MARK], mismatch_count,
			outcomes_due.size());
		if (mismatch_count == 0 && outcomes_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== maze_path_stack_search.f =====
sv/mps_pkg.sv
sv/mps_ctrl.sv
sv/mps_dp.sv
sv/maze_path_stack_search.sv
test/tb_maze_path_stack_search.sv
